// ----- rtl/core/ale_pkg.sv -----
// shared types, constants and saturation helper for the associated legendre evaluator
package ale_pkg;

  localparam int ALE_MAX_DEGREE = 8;

  localparam logic signed [63:0] ONE_Q40 = 64'sh0000_0100_0000_0000;
  localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;
  localparam logic signed [31:0] NEG_ONE_Q30 = 32'shC000_0000;
  localparam logic signed [63:0] POS_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] NEG_MIN = 64'sh8000_0000_0000_0000;

  typedef enum logic [1:0] {
    K_PASS,
    K_PMM,
    K_P1,
    K_REC
  } ale_kind_t;

  typedef struct packed {
    logic               bad;
    logic [3:0]         l;
    logic [4:0]         m;
    logic signed [31:0] x;
    logic [30:0]        somx2;
    logic signed [63:0] a;
    logic signed [63:0] b;
  } ale_ctx_t;

  function automatic logic signed [63:0] sat_mag(input logic neg, input logic [70:0] mag);
    logic signed [63:0] r;
    if (neg) begin
      if (mag >= 71'h0_8000_0000_0000_0000) begin
        r = NEG_MIN;
      end else begin
        r = -$signed(mag[63:0]);
      end
    end else if (mag > 71'h0_7FFF_FFFF_FFFF_FFFF) begin
      r = POS_MAX;
    end else begin
      r = $signed(mag[63:0]);
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/ale_sqrt.sv -----
// pipelined integer square root, one result bit per stage
module ale_sqrt (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_vld,
  input  ale_pkg::ale_ctx_t in_ctx,
  input  logic [61:0]       in_rad,
  output logic              out_vld,
  output ale_pkg::ale_ctx_t out_ctx
);
  import ale_pkg::*;

  localparam int NIT = 31;

  typedef struct packed {
    ale_ctx_t    c;
    logic [61:0] rad;
    logic [35:0] rem;
    logic [30:0] root;
  } sq_t;

  sq_t        pipe [0:NIT];
  sq_t        pipe_next [1:NIT];
  logic [NIT:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pipe[0].c    <= in_ctx;
      pipe[0].rad  <= in_rad;
      pipe[0].rem  <= '0;
      pipe[0].root <= '0;
    end
  end

  for (genvar i = 1; i <= NIT; i++) begin : g_it
    always_comb begin : c_it
      logic [35:0] rs;
      logic [35:0] tr;
      pipe_next[i]     = pipe[i-1];
      rs               = {pipe[i-1].rem[33:0], pipe[i-1].rad[61:60]};
      tr               = {3'b000, pipe[i-1].root, 2'b01};
      pipe_next[i].rad = {pipe[i-1].rad[59:0], 2'b00};
      if (rs >= tr) begin
        pipe_next[i].rem  = rs - tr;
        pipe_next[i].root = {pipe[i-1].root[29:0], 1'b1};
      end else begin
        pipe_next[i].rem  = rs;
        pipe_next[i].root = {pipe[i-1].root[29:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= vld[i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        pipe[i] <= pipe_next[i];
      end
    end
  end

  always_comb begin
    out_ctx       = pipe[NIT].c;
    out_ctx.somx2 = pipe[NIT].root;
  end

  assign out_vld = vld[NIT];

  // remainder never exceeds twice the root for a floor square root
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    vld[NIT] |-> pipe[NIT].rem <= {4'b0000, pipe[NIT].root, 1'b0})
    else $error("square root remainder out of bound");

endmodule

// ----- rtl/core/ale_step.sv -----
// one recurrence step: scaled multiply, saturating subtract and small-divisor division
module ale_step #(
  parameter int STEP = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_vld,
  input  ale_pkg::ale_ctx_t in_ctx,
  output logic              out_vld,
  output ale_pkg::ale_ctx_t out_ctx
);
  import ale_pkg::*;

  localparam int NDIV = 8;
  localparam int BPS  = 64 / NDIV;
  localparam int NST  = 6 + NDIV;
  localparam logic [4:0] N5 = 5'(STEP);
  localparam logic [4:0] F  = 5'(2 * STEP - 1);

  typedef struct packed {
    ale_ctx_t           c;
    ale_kind_t          kind;
    logic               mneg;
    logic               aneg;
    logic [63:0]        pp_lo;
    logic [63:0]        pp_hi;
    logic [68:0]        t2;
    logic signed [63:0] t2s;
    logic [95:0]        prod;
    logic [100:0]       prodf;
    logic signed [63:0] ms;
    logic               dneg;
    logic [63:0]        num;
    logic [3:0]         rem;
    logic [3:0]         d;
  } wk_t;

  wk_t          pipe [1:NST];
  wk_t          nx [1:NST];
  logic [NST:1] vld;

  // decode and partial products
  always_comb begin : c_s1
    logic [63:0] bmag;
    logic [63:0] amag;
    logic [31:0] smag;
    logic        sneg;
    logic [4:0]  g;
    nx[1]   = '0;
    nx[1].c = in_ctx;
    if (N5 > {1'b0, in_ctx.l}) begin
      nx[1].kind = K_PASS;
    end else if (N5 <= in_ctx.m) begin
      nx[1].kind = K_PMM;
    end else if (N5 == in_ctx.m + 5'd1) begin
      nx[1].kind = K_P1;
    end else begin
      nx[1].kind = K_REC;
    end
    bmag = in_ctx.b[63] ? 64'(-in_ctx.b) : 64'(in_ctx.b);
    amag = in_ctx.a[63] ? 64'(-in_ctx.a) : 64'(in_ctx.a);
    if (nx[1].kind == K_PMM) begin
      smag = {1'b0, in_ctx.somx2};
      sneg = 1'b0;
    end else begin
      smag = in_ctx.x[31] ? 32'(-in_ctx.x) : 32'(in_ctx.x);
      sneg = in_ctx.x[31];
    end
    nx[1].mneg  = in_ctx.b[63] ^ sneg;
    nx[1].aneg  = in_ctx.a[63];
    nx[1].pp_lo = 64'(bmag[31:0]) * 64'(smag);
    nx[1].pp_hi = 64'(bmag[63:32]) * 64'(smag);
    g           = (nx[1].kind == K_REC) ? N5 + in_ctx.m - 5'd1 : 5'd0;
    nx[1].t2    = 69'(amag) * 69'(g);
    nx[1].d     = (nx[1].kind == K_REC) ? 4'(N5 - in_ctx.m) : 4'd1;
  end

  always_comb begin
    nx[2]      = pipe[1];
    nx[2].prod = {pipe[1].pp_hi, 32'h0000_0000} + {32'h0000_0000, pipe[1].pp_lo};
    nx[2].t2s  = sat_mag(pipe[1].aneg, {2'b00, pipe[1].t2});
  end

  always_comb begin
    nx[3]       = pipe[2];
    nx[3].prodf = 101'(pipe[2].prod) * 101'(F);
  end

  always_comb begin
    nx[4]    = pipe[3];
    nx[4].ms = sat_mag(pipe[3].mneg, pipe[3].prodf[100:30]);
  end

  always_comb begin : c_s5
    logic signed [63:0] op_a;
    logic signed [63:0] op_b;
    logic signed [64:0] diff;
    logic signed [63:0] dv;
    nx[5] = pipe[4];
    case (pipe[4].kind)
      K_PMM: begin
        op_a = '0;
        op_b = pipe[4].ms;
      end
      K_P1: begin
        op_a = pipe[4].ms;
        op_b = '0;
      end
      K_REC: begin
        op_a = pipe[4].ms;
        op_b = pipe[4].t2s;
      end
      default: begin
        op_a = pipe[4].c.b;
        op_b = '0;
      end
    endcase
    diff = {op_a[63], op_a} - {op_b[63], op_b};
    if (diff[64] != diff[63]) begin
      dv = diff[64] ? NEG_MIN : POS_MAX;
    end else begin
      dv = diff[63:0];
    end
    nx[5].dneg = dv[63];
    nx[5].num  = dv[63] ? 64'(-dv) : 64'(dv);
    nx[5].rem  = '0;
  end

  for (genvar i = 6; i < 6 + NDIV; i++) begin : g_div
    always_comb begin : c_div
      logic [4:0]  r5;
      logic [3:0]  r;
      logic [63:0] q;
      nx[i] = pipe[i-1];
      r     = pipe[i-1].rem;
      q     = pipe[i-1].num;
      for (int j = 0; j < BPS; j++) begin
        r5 = {r, q[63]};
        q  = {q[62:0], 1'b0};
        if (r5 >= {1'b0, pipe[i-1].d}) begin
          r    = 4'(r5 - {1'b0, pipe[i-1].d});
          q[0] = 1'b1;
        end else begin
          r = r5[3:0];
        end
      end
      nx[i].rem = r;
      nx[i].num = q;
    end
  end

  always_comb begin
    nx[NST]     = pipe[NST-1];
    nx[NST].c.a = (pipe[NST-1].kind == K_PASS) ? pipe[NST-1].c.a : pipe[NST-1].c.b;
    nx[NST].c.b = pipe[NST-1].dneg ? -$signed(pipe[NST-1].num) : $signed(pipe[NST-1].num);
  end

  for (genvar i = 1; i <= NST; i++) begin : g_reg
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= (i == 1) ? in_vld : vld[(i > 1) ? i - 1 : 1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        pipe[i] <= nx[i];
      end
    end
  end

  assign out_vld = vld[NST];
  assign out_ctx = pipe[NST].c;

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    vld[5] |-> pipe[5].d != 4'd0)
    else $error("zero divisor in recurrence step");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    vld[5 + NDIV] |-> pipe[5 + NDIV].rem < pipe[5 + NDIV].d)
    else $error("division remainder not below divisor");

endmodule

// ----- rtl/core/associated_legendre_eval.sv -----
// associated legendre evaluator top level: input decode, square root, step chain, output
//
//  channel | valid     | stall     | payload
//  request | req_valid | req_stall | degree, order, arg_x
//  result  | rsp_valid | rsp_stall | value, bad_args
//
// the pipeline has one decode stage, 32 square root stages, 14 stages per recurrence step
// and one output register
// a new word is taken every cycle while the result side is not stalled
// rst is synchronous and clears only the valid bits
// a stalled result freezes the whole pipeline and holds req_stall high
module associated_legendre_eval #(
  parameter int MAX_DEGREE = ale_pkg::ALE_MAX_DEGREE
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  logic [3:0]         degree,
  input  logic signed [4:0]  order,
  input  logic signed [31:0] arg_x,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output logic signed [63:0] value,
  output logic               bad_args
);
  import ale_pkg::*;

  logic               en;
  logic               r_vld;
  logic [3:0]         r_degree;
  logic signed [4:0]  r_order;
  logic signed [31:0] r_x;
  logic [4:0]         mag;
  logic [31:0]        fac_p;
  logic [31:0]        fac_q;
  logic [63:0]        rad;
  ale_ctx_t           ctx0;
  ale_ctx_t           sc [0:MAX_DEGREE];
  logic [MAX_DEGREE:0] sv;

  assign en        = !(rsp_valid && rsp_stall);
  assign req_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      r_vld <= 1'b0;
    end else if (en) begin
      r_vld <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_degree <= degree;
      r_order  <= order;
      r_x      <= arg_x;
    end
  end

  always_comb begin
    mag        = r_order[4] ? 5'(-r_order) : 5'(r_order);
    fac_p      = 32'(ONE_Q30 - r_x);
    fac_q      = 32'(ONE_Q30 + r_x);
    rad        = 64'(fac_p) * 64'(fac_q);
    ctx0       = '0;
    ctx0.bad   = (r_degree > 4'(MAX_DEGREE)) || (mag > {1'b0, r_degree}) ||
                 (r_x > ONE_Q30) || (r_x < NEG_ONE_Q30);
    ctx0.l     = r_degree;
    ctx0.m     = mag;
    ctx0.x     = r_x;
    ctx0.b     = ONE_Q40;
  end

  ale_sqrt u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (r_vld),
    .in_ctx  (ctx0),
    .in_rad  (rad[61:0]),
    .out_vld (sv[0]),
    .out_ctx (sc[0])
  );

  for (genvar j = 1; j <= MAX_DEGREE; j++) begin : g_step
    ale_step #(
      .STEP (j)
    ) u_step (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .in_vld  (sv[j-1]),
      .in_ctx  (sc[j-1]),
      .out_vld (sv[j]),
      .out_ctx (sc[j])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (en) begin
      rsp_valid <= sv[MAX_DEGREE];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      value    <= sc[MAX_DEGREE].bad ? 64'sd0 : sc[MAX_DEGREE].b;
      bad_args <= sc[MAX_DEGREE].bad;
    end
  end

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && bad_args |-> value == 64'sd0)
    else $error("rejected word carries a nonzero value");

endmodule
